[src/sch_pkg.sv]
// shared types and constants of the spam co-occurrence histogram
// used by the top level and by its port checker; no dependencies
package sch_pkg;

	// request codes carried by req_type
	typedef enum logic [1:0] {
		REQ_COUNT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	// table codes carried by read_table
	typedef enum logic [1:0] {
		TBL_FM = 2'd0,
		TBL_FJ = 2'd1,
		TBL_SM = 2'd2,
		TBL_SJ = 2'd3
	} tbl_t;

	localparam int NTBL = 4;

	// field widths fixed by the item format
	localparam int REQ_W  = 2;
	localparam int DIR_W  = 3;
	localparam int DIFF_W = 9;
	localparam int TBL_W  = 2;
	localparam int IDX_W  = 9;

	// configuration registers
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 3;
	localparam int THR_FIRST_W  = 3;
	localparam int THR_SECOND_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SECOND = 1'b1;
	localparam logic [THR_FIRST_W-1:0]  THR_FIRST_RST  = 3'd4;
	localparam logic [THR_SECOND_W-1:0] THR_SECOND_RST = 2'd3;

endpackage

[src/spam_cooccurrence_histogram.sv]
// spam co-occurrence histogram: four count memories, read-modify-write per sample; uses sch_pkg
// one item per cycle while no sweep runs and no read result stalls; a read item's bin passes
// from the memory read register through the output register onto bin_count
// a count item reads all four tables at acceptance and writes back those it hits in the next
// cycle, with a forwarding register per table for back-to-back samples on the same bin
// reset and each clear item sweep the deepest table, req_ready low
module spam_cooccurrence_histogram #(
	parameter int MAX_FIRST_THRESHOLD  = 4,
	parameter int MAX_SECOND_THRESHOLD = 3,
	parameter int DIRECTIONS           = 8,
	parameter int COUNT_WIDTH          = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sch_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sch_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [sch_pkg::REQ_W-1:0]           req_type,
	input  logic [sch_pkg::DIR_W-1:0]           direction,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_a,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_b,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_c,
	input  logic                                use_triple,
	input  logic                                decrement,
	input  logic [sch_pkg::TBL_W-1:0]           read_table,
	input  logic [sch_pkg::IDX_W-1:0]           read_index,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [COUNT_WIDTH-1:0]              bin_count
);

	// table geometry, one slot per direction sized for the largest threshold
	localparam int SPAN1   = 2 * MAX_FIRST_THRESHOLD + 1;
	localparam int SPAN2   = 2 * MAX_SECOND_THRESHOLD + 1;
	localparam int SLOT_FM = SPAN1;
	localparam int SLOT_FJ = SPAN1 * SPAN1;
	localparam int SLOT_SM = SPAN2 * SPAN2;
	localparam int SLOT_SJ = SPAN2 * SPAN2 * SPAN2;
	localparam int D_FM    = DIRECTIONS * SLOT_FM;
	localparam int D_FJ    = DIRECTIONS * SLOT_FJ;
	localparam int D_SM    = DIRECTIONS * SLOT_SM;
	localparam int D_SJ    = DIRECTIONS * SLOT_SJ;
	localparam int D_F     = (D_FM > D_FJ) ? D_FM : D_FJ;
	localparam int D_S     = (D_SM > D_SJ) ? D_SM : D_SJ;
	localparam int SWEEP_LEN = (D_F > D_S) ? D_F : D_S;
	localparam int AMAX    = $clog2(SWEEP_LEN);

	// widths of thresholds, offsets and dense bin numbers
	localparam int T1W = $clog2(MAX_FIRST_THRESHOLD + 1);
	localparam int T2W = $clog2(MAX_SECOND_THRESHOLD + 1);
	localparam int OW1 = $clog2(SPAN1);
	localparam int OW2 = $clog2(SPAN2);
	localparam int PW1 = $clog2(SLOT_FJ);
	localparam int PW2 = $clog2(SLOT_SM);
	localparam int TW2 = $clog2(SLOT_SJ);
	localparam int XW  = sch_pkg::DIFF_W + 1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// configuration registers
	logic [sch_pkg::THR_FIRST_W-1:0]  thr_first_q;
	logic [sch_pkg::THR_SECOND_W-1:0] thr_second_q;

	// clearing sweep
	logic            sweep_q;
	logic [AMAX-1:0] sweep_cnt_q;

	// request decode
	logic req_fire;
	logic is_count;
	logic is_read;
	logic is_clear;
	logic dir_ok;
	logic read_ok;

	// clamped thresholds and widened differences
	logic [T1W-1:0]      t1;
	logic [T2W-1:0]      t2;
	logic signed [XW-1:0] ax, bx, cx, t1x, t2x;
	logic signed [XW-1:0] sa1, sb1, sa2, sb2, sc2;
	logic                in1a, in1b, in2a, in2b, in2c;
	logic [OW1-1:0]      oa1, ob1;
	logic [OW2-1:0]      oa2, ob2, oc2;
	logic [T1W:0]        span1_v;
	logic [T2W:0]        span2_v;
	logic [PW1-1:0]      pair1;
	logic [PW2-1:0]      pair2;
	logic [TW2-1:0]      trip2;

	// per table addresses, hits and data
	logic [sch_pkg::NTBL-1:0][AMAX-1:0]        cnt_addr;
	logic [sch_pkg::NTBL-1:0][AMAX-1:0]        rd_addr;
	logic [sch_pkg::NTBL-1:0]                  hit;
	logic [sch_pkg::NTBL-1:0][COUNT_WIDTH-1:0] rdata_q;
	logic [sch_pkg::NTBL-1:0][COUNT_WIDTH-1:0] old_val;
	logic [sch_pkg::NTBL-1:0][COUNT_WIDTH-1:0] new_val;
	logic [sch_pkg::NTBL-1:0]                  wr_s1;
	logic [sch_pkg::NTBL-1:0]                  fwd_valid_q;
	logic [sch_pkg::NTBL-1:0][AMAX-1:0]        fwd_addr_q;
	logic [sch_pkg::NTBL-1:0][COUNT_WIDTH-1:0] fwd_data_q;

	// stage 1: memory data is available, modify and write back
	logic                                      valid_s1;
	logic                                      is_read_s1;
	logic                                      read_ok_s1;
	logic                                      down_s1;
	logic [sch_pkg::TBL_W-1:0]                 table_s1;
	logic [sch_pkg::NTBL-1:0][AMAX-1:0]        addr_s1;
	logic [sch_pkg::NTBL-1:0]                  hit_s1;

	// output register
	logic                   rsp_valid_q;
	logic [COUNT_WIDTH-1:0] bin_count_q;
	logic                   rsp_load;
	logic                   stall;

	// ---------------------------------------------------------------------
	// handshake
	// a read in stage 1 can only hold when the output register is full and
	// not being taken; count items never hold
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign stall     = valid_s1 && is_read_s1 && rsp_valid_q && !rsp_ready;
	assign req_ready = !sweep_q && !stall;
	assign req_fire  = req_valid && req_ready;
	assign rsp_load  = valid_s1 && is_read_s1 && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign bin_count = bin_count_q;

	assign is_count = (req_type == sch_pkg::REQ_COUNT);
	assign is_read  = (req_type == sch_pkg::REQ_READ);
	assign is_clear = (req_type == sch_pkg::REQ_CLEAR);
	assign dir_ok   = int'(direction) < DIRECTIONS;

	// ---------------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_first_q  <= sch_pkg::THR_FIRST_RST;
			thr_second_q <= sch_pkg::THR_SECOND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sch_pkg::CFG_IDX_FIRST:  thr_first_q  <= cfg_data;
				sch_pkg::CFG_IDX_SECOND: thr_second_q <= cfg_data[sch_pkg::THR_SECOND_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// bin numbering of a count item
	// thresholds above the slot size saturate; an offset a+T is only used
	// when |a| <= T, so its low bits are the whole value
	// ---------------------------------------------------------------------
	always_comb begin
		if (int'(thr_first_q) > MAX_FIRST_THRESHOLD)
			t1 = T1W'(MAX_FIRST_THRESHOLD);
		else
			t1 = T1W'(thr_first_q);
		if (int'(thr_second_q) > MAX_SECOND_THRESHOLD)
			t2 = T2W'(MAX_SECOND_THRESHOLD);
		else
			t2 = T2W'(thr_second_q);

		ax  = XW'(diff_a);
		bx  = XW'(diff_b);
		cx  = XW'(diff_c);
		t1x = signed'(XW'(t1));
		t2x = signed'(XW'(t2));

		in1a = (ax <= t1x) && (ax >= -t1x);
		in1b = (bx <= t1x) && (bx >= -t1x);
		in2a = (ax <= t2x) && (ax >= -t2x);
		in2b = (bx <= t2x) && (bx >= -t2x);
		in2c = (cx <= t2x) && (cx >= -t2x);

		sa1 = ax + t1x;
		sb1 = bx + t1x;
		sa2 = ax + t2x;
		sb2 = bx + t2x;
		sc2 = cx + t2x;
		oa1 = sa1[OW1-1:0];
		ob1 = sb1[OW1-1:0];
		oa2 = sa2[OW2-1:0];
		ob2 = sb2[OW2-1:0];
		oc2 = sc2[OW2-1:0];

		// current span is 2T+1
		span1_v = {t1, 1'b1};
		span2_v = {t2, 1'b1};
		pair1 = PW1'(PW1'(oa1) * PW1'(span1_v) + PW1'(ob1));
		pair2 = PW2'(PW2'(oa2) * PW2'(span2_v) + PW2'(ob2));
		trip2 = TW2'(TW2'(pair2) * TW2'(span2_v) + TW2'(oc2));

		hit[sch_pkg::TBL_FM] = dir_ok && in1a;
		hit[sch_pkg::TBL_FJ] = dir_ok && in1a && in1b;
		hit[sch_pkg::TBL_SM] = dir_ok && use_triple && in2a && in2b;
		hit[sch_pkg::TBL_SJ] = dir_ok && use_triple && in2a && in2b && in2c;

		cnt_addr[sch_pkg::TBL_FM] = AMAX'(int'(direction) * SLOT_FM + int'(oa1));
		cnt_addr[sch_pkg::TBL_FJ] = AMAX'(int'(direction) * SLOT_FJ + int'(pair1));
		cnt_addr[sch_pkg::TBL_SM] = AMAX'(int'(direction) * SLOT_SM + int'(pair2));
		cnt_addr[sch_pkg::TBL_SJ] = AMAX'(int'(direction) * SLOT_SJ + int'(trip2));
	end

	// a read outside the direction's slot or of a missing direction gives zero
	always_comb begin
		unique case (read_table)
			sch_pkg::TBL_FM: read_ok = dir_ok && (int'(read_index) < SLOT_FM);
			sch_pkg::TBL_FJ: read_ok = dir_ok && (int'(read_index) < SLOT_FJ);
			sch_pkg::TBL_SM: read_ok = dir_ok && (int'(read_index) < SLOT_SM);
			sch_pkg::TBL_SJ: read_ok = dir_ok && (int'(read_index) < SLOT_SJ);
			default:         read_ok = 1'b0;
		endcase
	end

	// ---------------------------------------------------------------------
	// count memories, one per table
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < sch_pkg::NTBL; g++) begin : g_tbl
		localparam int DEPTH = (g == 0) ? D_FM : (g == 1) ? D_FJ : (g == 2) ? D_SM : D_SJ;
		localparam int SLOT  = (g == 0) ? SLOT_FM : (g == 1) ? SLOT_FJ :
		                       (g == 2) ? SLOT_SM : SLOT_SJ;
		localparam int AW    = $clog2(DEPTH);

		logic [COUNT_WIDTH-1:0] mem [DEPTH];
		logic                   wr_en;
		logic [AW-1:0]          wr_addr;
		logic [COUNT_WIDTH-1:0] wr_data;
		logic                   fwd_hit;

		assign rd_addr[g] = is_read ? AMAX'(int'(direction) * SLOT + int'(read_index))
		                            : cnt_addr[g];

		// the previous write has not reached the read data yet
		assign fwd_hit    = fwd_valid_q[g] && (fwd_addr_q[g] == addr_s1[g]);
		assign old_val[g] = fwd_hit ? fwd_data_q[g] : rdata_q[g];

		// saturating step in either direction
		always_comb begin
			if (down_s1)
				new_val[g] = (old_val[g] == '0) ? old_val[g] : old_val[g] - 1'b1;
			else
				new_val[g] = (old_val[g] == COUNT_MAX) ? old_val[g] : old_val[g] + 1'b1;
		end

		assign wr_s1[g] = valid_s1 && !is_read_s1 && hit_s1[g];

		always_comb begin
			if (sweep_q) begin
				wr_en   = int'(sweep_cnt_q) < DEPTH;
				wr_addr = sweep_cnt_q[AW-1:0];
				wr_data = '0;
			end else begin
				wr_en   = wr_s1[g];
				wr_addr = addr_s1[g][AW-1:0];
				wr_data = new_val[g];
			end
		end

		always_ff @(posedge clk) begin
			if (wr_en)
				mem[wr_addr] <= wr_data;
			if (req_fire)
				rdata_q[g] <= mem[rd_addr[g][AW-1:0]];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				fwd_valid_q[g] <= 1'b0;
			else if (sweep_q)
				fwd_valid_q[g] <= 1'b0;
			else if (wr_s1[g])
				fwd_valid_q[g] <= 1'b1;
		end

		always_ff @(posedge clk) begin
			if (wr_s1[g]) begin
				fwd_addr_q[g] <= addr_s1[g];
				fwd_data_q[g] <= new_val[g];
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 1 register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!stall)
			valid_s1 <= req_fire && (is_count || is_read);
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			is_read_s1 <= is_read;
			read_ok_s1 <= read_ok;
			down_s1    <= decrement;
			table_s1   <= read_table;
			addr_s1    <= rd_addr;
			// a read item writes nothing back
			hit_s1     <= is_count ? hit : '0;
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			bin_count_q <= read_ok_s1 ? old_val[table_s1] : '0;
	end

	// ---------------------------------------------------------------------
	// clearing sweep, after reset and for each clear item
	// the clear never enters stage 1, so a sample ahead of it has written
	// back before the sweep starts
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			if (sweep_cnt_q == AMAX'(SWEEP_LEN - 1))
				sweep_q <= 1'b0;
			else
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
		end else if (req_fire && is_clear) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

endmodule

[src/sch_checker.sv]
// port-level checks of the spam co-occurrence histogram and their binding
// depends on sch_pkg and spam_cooccurrence_histogram
module sch_checker #(
	parameter int COUNT_WIDTH = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [sch_pkg::REQ_W-1:0]     req_type,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [COUNT_WIDTH-1:0]        bin_count
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_count))
		else $error("result changed while stalled");

	// a fresh result follows an accepted read item
	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |->
		$past(req_valid && req_ready && (req_type == sch_pkg::REQ_READ), 2))
		else $error("result without a read item");

	// a clear blocks new items while the sweep runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == sch_pkg::REQ_CLEAR) |=> !req_ready)
		else $error("item taken right after a clear");

endmodule

bind spam_cooccurrence_histogram sch_checker #(
	.COUNT_WIDTH(COUNT_WIDTH)
) u_sch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_type  (req_type),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.bin_count (bin_count)
);

[bench/spam_cooccurrence_histogram_checker.sv]
// port checker of the spam co-occurrence histogram: mirrors the four count
// memories and the thresholds, predicts each read and compares bin_count
// depends on sch_pkg; watches the ports only
module spam_cooccurrence_histogram_checker #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [sch_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sch_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                req_valid,
	input  logic                                req_ready,
	input  logic [sch_pkg::REQ_W-1:0]           req_type,
	input  logic [sch_pkg::DIR_W-1:0]           direction,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_a,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_b,
	input  logic signed [sch_pkg::DIFF_W-1:0]   diff_c,
	input  logic                                use_triple,
	input  logic                                decrement,
	input  logic [sch_pkg::TBL_W-1:0]           read_table,
	input  logic [sch_pkg::IDX_W-1:0]           read_index,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  logic [COUNT_WIDTH-1:0]              bin_count,
	output int                                  fail_count,
	output int                                  outstanding
);

	localparam int MAX_T1  = 4;
	localparam int MAX_T2  = 3;
	localparam int NDIR    = 8;
	localparam int SPAN1   = 2 * MAX_T1 + 1;
	localparam int SPAN2   = 2 * MAX_T2 + 1;
	localparam int SLOT_FM = SPAN1;
	localparam int SLOT_FJ = SPAN1 * SPAN1;
	localparam int SLOT_SM = SPAN2 * SPAN2;
	localparam int SLOT_SJ = SPAN2 * SPAN2 * SPAN2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

	logic [sch_pkg::THR_FIRST_W-1:0]  thr_first;
	logic [sch_pkg::THR_SECOND_W-1:0] thr_second;
	logic [COUNT_WIDTH-1:0]  first_marg  [NDIR*SLOT_FM];
	logic [COUNT_WIDTH-1:0]  first_joint [NDIR*SLOT_FJ];
	logic [COUNT_WIDTH-1:0]  second_marg [NDIR*SLOT_SM];
	logic [COUNT_WIDTH-1:0]  second_joint[NDIR*SLOT_SJ];
	logic [COUNT_WIDTH-1:0]  expected_counts[$];
	logic [COUNT_WIDTH-1:0]  oldest_count;

	function automatic int magnitude(input int x);
		return (x < 0) ? -x : x;
	endfunction

	// saturating step in either direction
	function automatic logic [COUNT_WIDTH-1:0] stepped(input logic [COUNT_WIDTH-1:0] v,
			input bit down);
		if (down)
			return (v != '0) ? v - 1'b1 : v;
		return (v != COUNT_TOP) ? v + 1'b1 : v;
	endfunction

	task automatic wipe_tables();
		foreach (first_marg[i]) first_marg[i] = '0;
		foreach (first_joint[i]) first_joint[i] = '0;
		foreach (second_marg[i]) second_marg[i] = '0;
		foreach (second_joint[i]) second_joint[i] = '0;
	endtask

	task automatic tally_sample(input int dir, input int a, input int b, input int c,
			input bit triple, input bit down);
		int t1, t2, s1, s2, pair, k;
		t1 = (thr_first > MAX_T1) ? MAX_T1 : int'(thr_first);
		t2 = (thr_second > MAX_T2) ? MAX_T2 : int'(thr_second);
		s1 = 2 * t1 + 1;
		s2 = 2 * t2 + 1;
		if (magnitude(a) <= t1) begin
			k = dir * SLOT_FM + a + t1;
			first_marg[k] = stepped(first_marg[k], down);
			if (magnitude(b) <= t1) begin
				k = dir * SLOT_FJ + (a + t1) * s1 + (b + t1);
				first_joint[k] = stepped(first_joint[k], down);
			end
		end
		if (triple && magnitude(a) <= t2 && magnitude(b) <= t2) begin
			pair = (a + t2) * s2 + (b + t2);
			k = dir * SLOT_SM + pair;
			second_marg[k] = stepped(second_marg[k], down);
			if (magnitude(c) <= t2) begin
				k = dir * SLOT_SJ + pair * s2 + (c + t2);
				second_joint[k] = stepped(second_joint[k], down);
			end
		end
	endtask

	// raw slot entry; anything past the slot reads as zero
	function automatic logic [COUNT_WIDTH-1:0] bin_value(input int dir,
			input sch_pkg::tbl_t tbl, input int idx);
		if (dir >= NDIR)
			return '0;
		case (tbl)
			sch_pkg::TBL_FM: return (idx < SLOT_FM) ? first_marg[dir*SLOT_FM + idx] : '0;
			sch_pkg::TBL_FJ: return (idx < SLOT_FJ) ? first_joint[dir*SLOT_FJ + idx] : '0;
			sch_pkg::TBL_SM: return (idx < SLOT_SM) ? second_marg[dir*SLOT_SM + idx] : '0;
			default: return (idx < SLOT_SJ) ? second_joint[dir*SLOT_SJ + idx] : '0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_first = sch_pkg::THR_FIRST_RST;
			thr_second = sch_pkg::THR_SECOND_RST;
			wipe_tables();
			expected_counts.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_counts.size() == 0) begin
					$error("bin_count: no read waiting, actual %0d", bin_count);
					fail_count++;
				end else begin
					oldest_count = expected_counts.pop_front();
					if (bin_count !== oldest_count) begin
						$error("bin_count: expected %0d, actual %0d", oldest_count, bin_count);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sch_pkg::CFG_IDX_FIRST:
						thr_first = cfg_data[sch_pkg::THR_FIRST_W-1:0];
					sch_pkg::CFG_IDX_SECOND:
						thr_second = cfg_data[sch_pkg::THR_SECOND_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				case (req_type)
					sch_pkg::REQ_COUNT: tally_sample(int'(direction), int'(diff_a),
						int'(diff_b), int'(diff_c), use_triple, decrement);
					sch_pkg::REQ_READ: expected_counts.push_back(bin_value(int'(direction),
						sch_pkg::tbl_t'(read_table), int'(read_index)));
					sch_pkg::REQ_CLEAR: wipe_tables();
					default: ;
				endcase
			end
			outstanding = expected_counts.size();
		end
	end

endmodule

[bench/spam_cooccurrence_histogram_tb.sv]
// testbench top of the spam co-occurrence histogram: clock, reset, request
// and configuration stimulus, response stalls, watchdog and verdict
// depends on sch_pkg, the block and spam_cooccurrence_histogram_checker
module spam_cooccurrence_histogram_tb;

	localparam int COUNT_WIDTH = 24;
	// a clearing sweep accepts nothing while it runs
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_ITEMS = 190;
	localparam int NPHASE      = 7;
	localparam logic [sch_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sch_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [sch_pkg::REQ_W-1:0] req_type = '0;
	logic [sch_pkg::DIR_W-1:0] direction = '0;
	logic signed [sch_pkg::DIFF_W-1:0] diff_a = '0;
	logic signed [sch_pkg::DIFF_W-1:0] diff_b = '0;
	logic signed [sch_pkg::DIFF_W-1:0] diff_c = '0;
	logic use_triple = 1'b0;
	logic decrement = 1'b0;
	logic [sch_pkg::TBL_W-1:0] read_table = '0;
	logic [sch_pkg::IDX_W-1:0] read_index = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [COUNT_WIDTH-1:0] bin_count;
	int fail_count;
	int outstanding;

	// effective thresholds of the current phase, only to aim the stimulus
	int cur_t1 = 4;
	int cur_t2 = 3;
	int reach = 5;
	// sender pacing: item burst left before the next gap, off in one phase
	int burst_left = 0;
	bit paced = 1'b1;
	// receiver stall pattern
	logic [11:0] rsp_cycle = '0;
	logic [1:0] drain_mode = '0;
	int quiet_cycles = 0;

	spam_cooccurrence_histogram dut (.*);
	spam_cooccurrence_histogram_checker #(.COUNT_WIDTH(COUNT_WIDTH)) watch (.*);

	always #4 clk = ~clk;

	// receiver: pick a new stall style each time rsp_cycle[6:0] returns to zero
	always @(posedge clk) begin
		rsp_cycle <= rsp_cycle + 1'b1;
		if (rsp_cycle[6:0] == '0)
			drain_mode <= 2'($urandom_range(3));
		case (drain_mode)
			2'd0: rsp_ready <= 1'b1;
			2'd1: rsp_ready <= 1'($urandom_range(1));
			2'd2: rsp_ready <= (rsp_cycle[1:0] == 2'b00);
			default: rsp_ready <= (rsp_cycle[4:3] != 2'b11);
		endcase
	end

	// watchdog: too long without any handshake on any channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one item, hold it until accepted, then maybe open a gap
	// called and returns at a rising edge
	task automatic issue(input logic [sch_pkg::REQ_W-1:0] kind, input int dir, input int a,
			input int b, input int c, input bit triple, input bit down, input int tbl,
			input int idx);
		int gap;
		req_valid <= 1'b1;
		req_type <= kind;
		direction <= dir[sch_pkg::DIR_W-1:0];
		diff_a <= a[sch_pkg::DIFF_W-1:0];
		diff_b <= b[sch_pkg::DIFF_W-1:0];
		diff_c <= c[sch_pkg::DIFF_W-1:0];
		use_triple <= triple;
		decrement <= down;
		read_table <= tbl[sch_pkg::TBL_W-1:0];
		read_index <= idx[sch_pkg::IDX_W-1:0];
		// ready is stable at the falling edge; the next rising edge takes the item
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else if (paced) begin
			burst_left = $urandom_range(24);
			gap = $urandom_range(6, 1);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic count_item(input int dir, input int a, input int b, input int c,
			input bit triple, input bit down);
		issue(sch_pkg::REQ_COUNT, dir, a, b, c, triple, down, 0, 0);
	endtask

	task automatic read_item(input int dir, input int tbl, input int idx);
		issue(sch_pkg::REQ_READ, dir, 0, 0, 0, 1'b0, 1'b0, tbl, idx);
	endtask

	// write both threshold registers back to back, valid held between them
	task automatic configure(input int first, input int second);
		cfg_valid <= 1'b1;
		cfg_index <= sch_pkg::CFG_IDX_FIRST;
		cfg_data <= first[sch_pkg::CFG_DATA_W-1:0];
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_index <= sch_pkg::CFG_IDX_SECOND;
		cfg_data <= second[sch_pkg::CFG_DATA_W-1:0];
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_t1 = (first > 4) ? 4 : first;
		cur_t2 = (second > 3) ? 3 : second;
		reach = ((cur_t1 > cur_t2) ? cur_t1 : cur_t2) + 1;
	endtask

	// a final read queues behind any clearing sweep, so once it is back the
	// block is idle; the closing wait covers the write-back of the last sample
	task automatic quiesce();
		read_item(0, sch_pkg::TBL_FM, 0);
		req_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// mostly differences near the threshold so bins fill, some over the full range
	function automatic int pick_diff();
		if ($urandom_range(4) == 0)
			return int'($urandom_range(510)) - 255;
		return int'($urandom_range(2 * reach)) - reach;
	endfunction

	task automatic random_traffic(input int items, input int hot_dir);
		int done, roll, dir, spread, idx;
		sch_pkg::tbl_t tbl;
		done = 0;
		while (done < items) begin
			roll = $urandom_range(99);
			// most traffic on two neighbouring directions so reads find counts
			dir = ($urandom_range(3) == 0) ? $urandom_range(7) : (hot_dir + $urandom_range(1)) % 8;
			if (roll < 2) begin
				// unused request code, ignored by the block
				issue(REQ_UNUSED, dir, pick_diff(), pick_diff(), pick_diff(), 1'b1, 1'b0,
					$urandom_range(3), $urandom_range(342));
			end else begin
				done++;
				if (roll < 3) begin
					issue(sch_pkg::REQ_CLEAR, dir, 0, 0, 0, 1'b0, 1'b0, 0, 0);
				end else if (roll < 38) begin
					tbl = sch_pkg::tbl_t'($urandom_range(3));
					case (tbl)
						sch_pkg::TBL_FM: spread = 2 * cur_t1 + 1;
						sch_pkg::TBL_FJ: spread = (2 * cur_t1 + 1) ** 2;
						sch_pkg::TBL_SM: spread = (2 * cur_t2 + 1) ** 2;
						default: spread = (2 * cur_t2 + 1) ** 3;
					endcase
					// a quarter anywhere in the index range, past the slot too
					idx = ($urandom_range(3) == 0) ? $urandom_range(342) : $urandom_range(spread - 1);
					read_item(dir, tbl, idx);
				end else begin
					count_item(dir, pick_diff(), pick_diff(), pick_diff(),
						$urandom_range(9) < 7, $urandom_range(4) == 0);
				end
			end
		end
	endtask

	initial begin
		int first_thr[NPHASE];
		int second_thr[NPHASE];
		// reset values, minimum, first above maximum, zero, middle, mixed
		first_thr = '{4, 1, 7, 0, 2, 5, 3};
		second_thr = '{3, 1, 3, 0, 2, 0, 1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		configure(4, 3);

		// directed: bins at the threshold edges, out of range differences,
		// second order marginal without joint, decrement at zero, ignored code
		read_item(0, sch_pkg::TBL_SJ, 342);
		count_item(0, 0, 0, 0, 1'b1, 1'b0);
		count_item(0, 4, -4, 3, 1'b1, 1'b0);
		count_item(0, -4, 4, -3, 1'b1, 1'b0);
		count_item(7, 255, -255, 255, 1'b1, 1'b0);
		count_item(7, -255, 255, -255, 1'b0, 1'b0);
		count_item(0, -3, 2, 5, 1'b1, 1'b0);
		count_item(0, 1, 5, 0, 1'b1, 1'b0);
		count_item(1, 1, 1, 1, 1'b1, 1'b1);
		issue(REQ_UNUSED, 2, 0, 0, 0, 1'b1, 1'b0, 0, 0);
		read_item(0, sch_pkg::TBL_FM, 4);
		read_item(0, sch_pkg::TBL_FJ, 40);
		read_item(0, sch_pkg::TBL_SM, 24);
		read_item(0, sch_pkg::TBL_SJ, 171);
		// index past the slot of the first marginal table
		read_item(0, sch_pkg::TBL_FM, 9);
		read_item(0, sch_pkg::TBL_FJ, 72);
		read_item(7, sch_pkg::TBL_SJ, 0);
		read_item(1, sch_pkg::TBL_SJ, 228);
		count_item(0, 0, 0, 0, 1'b1, 1'b1);
		read_item(0, sch_pkg::TBL_FJ, 40);
		issue(sch_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
		read_item(0, sch_pkg::TBL_FM, 4);
		quiesce();

		// phases keep their counts across threshold changes unless cleared
		for (int p = 0; p < NPHASE; p++) begin
			configure(first_thr[p], second_thr[p]);
			paced = (p != 2);
			random_traffic(PHASE_ITEMS, $urandom_range(7));
			quiesce();
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
src/sch_pkg.sv
src/spam_cooccurrence_histogram.sv
src/sch_checker.sv
bench/spam_cooccurrence_histogram_checker.sv
bench/spam_cooccurrence_histogram_tb.sv
